// ===== hdl/assert_macros.svh =====
// Assertion macros used by the matcher sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/tdm_pkg.sv =====
// Types and constants shared by the table-driven string matcher modules.
package tdm_pkg;

  // Stream payload widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // Item kinds carried on the input tuser bit
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // First character code that rejects the match
  localparam logic [20:0] REJECT_CODE = 21'd127;
  // Remembered result meaning "no final transition seen"
  localparam logic [15:0] RESULT_NONE = 16'hFFFF;

  typedef enum logic [2:0] {
    STAT_LOADED     = 3'd0,
    STAT_CONTINUING = 3'd1,
    STAT_MATCHED    = 3'd2,
    STAT_NOMATCH    = 3'd3,
    STAT_REJECTED   = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_RES
  } seq_state_t;

  // One stored transition
  typedef struct packed {
    logic        [10:0] src;
    logic        [6:0]  chr;
    logic        [10:0] dst;
    logic signed [15:0] res;
  } entry_t;

  // Item handed from the input port to the sequencer
  typedef struct packed {
    logic        start;
    logic        op;
    logic [20:0] code;
    logic        eot;
  } seq_req_t;

  // One result item
  typedef struct packed {
    status_t     status;
    logic [14:0] offset;
    logic        consumed;
  } result_t;

endpackage

// ===== hdl/tdm_table.sv =====
// Transition table memory: one write port, one registered read port.
module tdm_table #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  tdm_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output tdm_pkg::entry_t rdata
);
  import tdm_pkg::*;

  entry_t mem [DEPTH];
  entry_t rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tdm_seq.sv =====
// Scan sequencer: walks the table one entry per cycle through a shared comparator.
`include "assert_macros.svh"
module tdm_seq #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tdm_pkg::seq_req_t req,
  input  logic [10:0]       table_entries,
  output logic [AW-1:0]     rd_addr,
  input  tdm_pkg::entry_t   rd_data,
  output logic              idle,
  output logic              res_valid,
  input  logic              res_ready,
  output tdm_pkg::result_t  res
);
  import tdm_pkg::*;

  // counter wide enough for both the depth and the 11-bit entry count
  localparam int LW = (AW + 1 > 11) ? AW + 1 : 11;

  seq_state_t  state_r, state_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          pend_r, pend_nxt;
  logic [10:0]   cur_r, cur_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [6:0]    code_r, code_nxt;
  logic          eot_r, eot_nxt;
  result_t       res_r, res_nxt;

  logic [LW-1:0] entries_w;
  logic [LW-1:0] depth_w;
  logic [LW-1:0] limit_w;
  logic          hit;

  // match ends: judge the remembered result
  function automatic result_t judge(input logic [15:0] r, input logic c);
    result_t o;
    o.consumed = c;
    if (!r[15]) begin
      o.status = STAT_MATCHED;
      o.offset = r[14:0];
    end else begin
      o.status = STAT_NOMATCH;
      o.offset = '0;
    end
    return o;
  endfunction

  // scan limit is the entry count capped at the table depth
  assign entries_w = LW'(table_entries);
  assign depth_w   = LW'(DEPTH);
  assign limit_w   = (entries_w > depth_w) ? depth_w : entries_w;

  // shared comparator on the entry read last cycle
  assign hit = pend_r && (rd_data.src == cur_r) && (rd_data.chr == code_r);

  assign rd_addr   = cnt_r[AW-1:0];
  assign idle      = (state_r == SEQ_IDLE);
  assign res_valid = (state_r == SEQ_RES);
  assign res       = res_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_IDLE;
      cnt_r   <= '0;
      pend_r  <= 1'b0;
      cur_r   <= '0;
      rem_r   <= RESULT_NONE;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      cur_r   <= cur_nxt;
      rem_r   <= rem_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    eot_r  <= eot_nxt;
    res_r  <= res_nxt;
  end

  // next state and datapath control
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    cur_nxt   = cur_r;
    rem_nxt   = rem_r;
    code_nxt  = code_r;
    eot_nxt   = eot_r;
    res_nxt   = res_r;
    case (state_r)
      SEQ_IDLE: begin
        if (req.start) begin
          if (req.op == OP_LOAD) begin
            res_nxt   = '{status: STAT_LOADED, offset: '0, consumed: 1'b0};
            state_nxt = SEQ_RES;
          end else if (req.code >= REJECT_CODE) begin
            res_nxt   = '{status: STAT_REJECTED, offset: '0, consumed: 1'b0};
            cur_nxt   = '0;
            rem_nxt   = RESULT_NONE;
            state_nxt = SEQ_RES;
          end else begin
            // slot 0 is read at this edge
            code_nxt  = req.code[6:0];
            eot_nxt   = req.eot;
            cnt_nxt   = cnt_r + 1'b1;
            pend_nxt  = (cnt_r < limit_w);
            state_nxt = SEQ_SCAN;
          end
        end
      end
      SEQ_SCAN: begin
        if (hit) begin
          cnt_nxt   = '0;
          pend_nxt  = 1'b0;
          state_nxt = SEQ_RES;
          if (eot_r) begin
            res_nxt = judge(rd_data.res, 1'b1);
            cur_nxt = '0;
            rem_nxt = RESULT_NONE;
          end else begin
            res_nxt = '{status: STAT_CONTINUING, offset: '0, consumed: 1'b1};
            cur_nxt = rd_data.dst;
            rem_nxt = rd_data.res;
          end
        end else if (!pend_r) begin
          // table exhausted without a transition
          res_nxt   = judge(rem_r, 1'b0);
          cur_nxt   = '0;
          rem_nxt   = RESULT_NONE;
          cnt_nxt   = '0;
          state_nxt = SEQ_RES;
        end else begin
          cnt_nxt  = cnt_r + 1'b1;
          pend_nxt = (cnt_r < limit_w);
        end
      end
      SEQ_RES: begin
        if (res_ready) begin
          state_nxt = SEQ_IDLE;
        end
      end
      default: begin
        state_nxt = SEQ_IDLE;
      end
    endcase
  end

  `ASSERT_CLK(a_start_when_idle, clk, rst_n, req.start |-> state_r == SEQ_IDLE, "item started while busy")
  `ASSERT_CLK(a_cnt_parked, clk, rst_n, state_r != SEQ_SCAN |-> cnt_r == '0 && !pend_r, "scan counter not parked")
  `ASSERT_CLK(a_cnt_bound, clk, rst_n, state_r == SEQ_SCAN |-> cnt_r <= limit_w + 1'b1, "scan ran past the limit")
  `ASSERT_NEVER(a_end_clears, clk, rst_n, res_valid && (res_r.status == STAT_MATCHED || res_r.status == STAT_NOMATCH || res_r.status == STAT_REJECTED) && (cur_r != '0 || rem_r != RESULT_NONE), "automaton not reset after match end")

endmodule

// ===== hdl/trie_dfa_string_matcher_top.sv =====
// Top level of the table-driven DFA string matcher.
//
// Input channel in_*: tuser is the item kind (0 load a table entry, 1 text
// character), tlast marks the last character of a text. A load item writes
// one transition slot; a character item takes one step of the automaton.
// Output channel out_*: one result item per input item, status in tuser,
// match offset and consumed flag in tdata.
// cfg_wr_en/cfg_wr_data set the number of valid table entries; the user
// must write it only while idle: the block does not enforce this. A load
// item, or a text character with code 127 or above, has its result put in
// the sequencer's result register and then the output register; other
// characters scan the table from slot 0, one entry per cycle through the
// single comparator, up to the first hit or min(table_entries, TABLE_DEPTH)
// entries. One item is worked on at a time; in_tready is high only while
// the sequencer is idle. The result sits in an output register; while the
// receiver stalls, one more finished result waits in the sequencer and
// input stays blocked. Reset (rst_n low, synchronous) clears the entry
// count, the automaton state and the remembered result; the table memory
// keeps its contents and is undefined until loaded.
module trie_dfa_string_matcher_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration: table_entries
  input  logic                            cfg_wr_en,
  input  logic [10:0]                     cfg_wr_data,
  // input channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // tdata: entry_index[9:0], entry_source[20:10], entry_char[27:21],
  //        entry_target[38:28], entry_result[54:39], char_code[75:55], zero[79:76]
  input  logic [tdm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // tuser: op
  input  logic                            in_tuser,
  // tlast: end_of_text
  input  logic                            in_tlast,
  // output channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tdata: match_offset[14:0], consumed[15]
  output logic [tdm_pkg::OUT_TDATA_W-1:0] out_tdata,
  // tuser: status[2:0]
  output logic [2:0]                      out_tuser
);
  import tdm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int IW = (AW + 1 > 11) ? AW + 1 : 11;

  logic [10:0]   entries_r;
  logic          in_acc;
  seq_req_t      req;
  entry_t        wr_entry;
  entry_t        rd_entry;
  logic [9:0]    wr_index;
  logic          tbl_we;
  logic [AW-1:0] rd_addr;
  logic          seq_idle;
  logic          res_valid;
  logic          res_take;
  result_t       res;
  logic          out_vld_r, out_vld_nxt;
  result_t       out_r, out_nxt;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= '0;
    end else if (cfg_wr_en) begin
      entries_r <= cfg_wr_data;
    end
  end

  // input unpacking
  assign in_tready    = seq_idle;
  assign in_acc       = in_tvalid && in_tready;
  assign wr_index     = in_tdata[9:0];
  assign wr_entry.src = in_tdata[20:10];
  assign wr_entry.chr = in_tdata[27:21];
  assign wr_entry.dst = in_tdata[38:28];
  assign wr_entry.res = in_tdata[54:39];
  assign req.start    = in_acc;
  assign req.op       = in_tuser;
  assign req.code     = in_tdata[75:55];
  assign req.eot      = in_tlast;

  // load write, slots beyond the table are dropped
  assign tbl_we = in_acc && (in_tuser == OP_LOAD) && (IW'(wr_index) < IW'(TABLE_DEPTH));

  tdm_table #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(wr_index)),
    .wdata (wr_entry),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  tdm_seq #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .req           (req),
    .table_entries (entries_r),
    .rd_addr       (rd_addr),
    .rd_data       (rd_entry),
    .idle          (seq_idle),
    .res_valid     (res_valid),
    .res_ready     (res_take),
    .res           (res)
  );

  // output register
  assign res_take = res_valid && (!out_vld_r || out_tready);

  always_comb begin
    out_vld_nxt = out_vld_r;
    out_nxt     = out_r;
    if (res_take) begin
      out_vld_nxt = 1'b1;
      out_nxt     = res;
    end else if (out_tready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_r.consumed, out_r.offset};
  assign out_tuser  = out_r.status;

endmodule

// ===== test/trie_dfa_string_matcher_checker.sv =====
// Result checker for the table-driven string matcher: tracks the automaton and compares results.
module trie_dfa_string_matcher_checker #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [10:0]                     cfg_wr_data,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [tdm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tuser,
  input  logic                            in_tlast,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [tdm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [2:0]                      out_tuser,
  output int                              results_due,
  output int                              mismatches
);
  timeunit 1ns;
  timeprecision 1ps;
  import tdm_pkg::*;

  // Shadow of the block: transition table, walk state, entry count
  entry_t      trans_tbl [TABLE_DEPTH];
  logic [10:0] dfa_state;
  logic [15:0] last_result;
  logic [10:0] entry_count;
  result_t     awaited_results [$];
  int          bad_items = 0;

  // End of a match: judge the remembered result, then back to the start state
  function automatic result_t close_match(input logic took);
    result_t r;
    if (!last_result[15]) begin
      r.status = STAT_MATCHED;
      r.offset = last_result[14:0];
    end else begin
      r.status = STAT_NOMATCH;
      r.offset = '0;
    end
    r.consumed  = took;
    dfa_state   = '0;
    last_result = RESULT_NONE;
    return r;
  endfunction

  // Result of one item; updates the shadow state
  function automatic result_t next_match_result(input logic op,
                                                input logic [IN_TDATA_W-1:0] data,
                                                input logic eot);
    result_t     r;
    logic [9:0]  slot;
    logic [20:0] code;
    int          lim;
    logic        hit;
    r.status   = STAT_LOADED;
    r.offset   = '0;
    r.consumed = 1'b0;
    if (op == OP_LOAD) begin
      slot = data[9:0];
      if (slot < TABLE_DEPTH) begin
        trans_tbl[slot].src = data[20:10];
        trans_tbl[slot].chr = data[27:21];
        trans_tbl[slot].dst = data[38:28];
        trans_tbl[slot].res = data[54:39];
      end
      return r;
    end
    code = data[75:55];
    // a code of 127 or above kills the match whatever was remembered
    if (code >= REJECT_CODE) begin
      dfa_state   = '0;
      last_result = RESULT_NONE;
      r.status    = STAT_REJECTED;
      return r;
    end
    // first matching entry wins
    lim = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
    hit = 1'b0;
    for (int i = 0; i < lim; i++) begin
      if (!hit && trans_tbl[i].src == dfa_state && trans_tbl[i].chr == code[6:0]) begin
        hit         = 1'b1;
        dfa_state   = trans_tbl[i].dst;
        last_result = trans_tbl[i].res;
      end
    end
    if (!hit) return close_match(1'b0);
    if (eot) return close_match(1'b1);
    r.status   = STAT_CONTINUING;
    r.consumed = 1'b1;
    return r;
  endfunction

  // Watch both channels and the register port at every edge
  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      dfa_state   = '0;
      last_result = RESULT_NONE;
      entry_count = '0;
      awaited_results.delete();
    end else begin
      if (cfg_wr_en) entry_count = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result item: status %0d offset %0d consumed %0d",
                   $time, out_tuser, out_tdata[14:0], out_tdata[15]);
          bad_items++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tuser !== want.status || out_tdata[14:0] !== want.offset ||
              out_tdata[15] !== want.consumed) begin
            $display("%0t: mismatch: expected status %0d offset %0d consumed %0d, got status %0d offset %0d consumed %0d",
                     $time, want.status, want.offset, want.consumed,
                     out_tuser, out_tdata[14:0], out_tdata[15]);
            bad_items++;
          end
        end
      end
      if (in_tvalid && in_tready)
        awaited_results.push_back(next_match_result(in_tuser, in_tdata, in_tlast));
    end
    results_due <= awaited_results.size();
    mismatches  <= bad_items;
  end

endmodule

// ===== test/tb.sv =====
// Testbench top for the table-driven string matcher: stimulus, flow control and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tdm_pkg::*;

  localparam int          TABLE_DEPTH = 1024;
  localparam int          LONG_HOLD   = 300;
  localparam longint      TIMEOUT_NS  = 20_000_000;
  localparam logic [20:0] CH_A = 21'h61;
  localparam logic [20:0] CH_B = 21'h62;
  localparam logic [20:0] CH_C = 21'h63;
  localparam logic [20:0] CH_X = 21'h78;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [10:0]            cfg_wr_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tlast;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [2:0]             out_tuser;
  int                     results_due;
  int                     mismatches;

  // Sender bookkeeping and a copy of the table for building texts
  bit          offering;
  bit          hold_request;
  int          burst_left;
  int          items_sent;
  int          active_slots;
  logic [10:0] tb_src [TABLE_DEPTH];
  logic [6:0]  tb_chr [TABLE_DEPTH];
  logic [10:0] tb_dst [TABLE_DEPTH];

  always #5 clk = ~clk;

  trie_dfa_string_matcher_top #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  trie_dfa_string_matcher_checker #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) match_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .results_due (results_due),
    .mismatches  (mismatches)
  );

  // Offer one item, hold it until taken, then maybe end the burst with a gap
  task automatic push_item(input logic op, input logic [IN_TDATA_W-1:0] data,
                           input logic last);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= data;
    in_tlast  <= last;
    offering = 1'b1;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 16);
      case ($urandom_range(3))
        0: gap = 0;
        1: gap = $urandom_range(1, 2);
        2: gap = $urandom_range(3, 8);
        default: gap = $urandom_range(1, 30);
      endcase
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_load(input logic [9:0] slot, input logic [10:0] src,
                           input logic [6:0] chr, input logic [10:0] dst,
                           input logic [15:0] res);
    tb_src[slot] = src;
    tb_chr[slot] = chr;
    tb_dst[slot] = dst;
    // char field and tlast are don't-care on a load: randomize them
    push_item(OP_LOAD, {4'b0, 21'($urandom), res, dst, chr, src, slot}, 1'($urandom));
  endtask

  task automatic send_char(input logic [20:0] code, input logic eot);
    // load fields are don't-care on a character
    push_item(OP_CHAR, {4'b0, code, 16'($urandom), 11'($urandom), 7'($urandom),
                        11'($urandom), 10'($urandom)}, eot);
  endtask

  // Mostly a small alphabet so that keys collide, now and then any code
  function automatic logic [6:0] pick_char();
    case ($urandom_range(19))
      0:          return 7'd127;
      1, 2, 3, 4: return 7'($urandom_range(126));
      default:    return 7'(8'h61 + $urandom_range(3));
    endcase
  endfunction

  // Stop offering and wait until every result is back
  task automatic wait_all_results();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  task automatic set_entry_count(input logic [10:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    active_slots = (value > TABLE_DEPTH) ? TABLE_DEPTH : int'(value);
  endtask

  // Random tree of transitions in slots 0..n-1, with some back edges
  task automatic grow_trie(input int n);
    int          pool [$];
    int          fresh;
    logic [10:0] src;
    logic [10:0] dst;
    logic [15:0] res;
    pool.push_back(0);
    fresh = 1;
    for (int i = 0; i < n; i++) begin
      src = 11'(pool[$urandom_range(pool.size() - 1)]);
      if ($urandom_range(9) < 8 && fresh < 2048) begin
        dst = 11'(fresh);
        pool.push_back(fresh);
        fresh++;
      end else begin
        dst = 11'(pool[$urandom_range(pool.size() - 1)]);
      end
      case ($urandom_range(19))
        0:       res = 16'd0;
        1:       res = 16'd32767;
        2:       res = 16'($urandom_range(16'h8000, 16'hFFFE));
        3, 4, 5, 6, 7, 8:
                 res = 16'($urandom_range(32767));
        default: res = 16'hFFFF;
      endcase
      send_load(10'(i), src, pick_char(), dst, res);
    end
  endtask

  // Text that mostly follows existing transitions from state 0
  task automatic emit_text();
    int          len;
    int          hop;
    logic [10:0] cur;
    logic [20:0] code;
    logic [6:0]  opts [$];
    len = $urandom_range(1, 12);
    cur = '0;
    for (int k = 0; k < len; k++) begin
      opts.delete();
      for (int i = 0; i < active_slots; i++)
        if (tb_src[i] == cur && tb_chr[i] != 7'd127) opts.push_back(tb_chr[i]);
      if (opts.size() > 0 && $urandom_range(99) < 88)
        code = 21'(opts[$urandom_range(opts.size() - 1)]);
      else if ($urandom_range(99) < 6)
        code = 21'($urandom_range(127, 21'h1FFFFF));
      else
        code = 21'(pick_char());
      send_char(code, k == len - 1);
      // follow the walk so the next character can continue it
      hop = -1;
      if (code < REJECT_CODE)
        for (int i = 0; i < active_slots; i++)
          if (hop < 0 && tb_src[i] == cur && tb_chr[i] == code[6:0]) hop = int'(tb_dst[i]);
      cur = (hop < 0 || k == len - 1) ? 11'd0 : 11'(hop);
    end
  endtask

  // One table setting: write the count, fill the table, then random traffic
  task automatic run_phase(input logic [10:0] entries, input bit rebuild, input int quota,
                           input int hold_at, input int pause_at);
    int          first;
    logic [20:0] code;
    logic [9:0]  slot;
    wait_all_results();
    set_entry_count(entries);
    if (rebuild) grow_trie(active_slots);
    first = items_sent;
    for (int k = 0; items_sent - first < quota; k++) begin
      if (k == hold_at) hold_request = 1'b1;
      if (k == pause_at) wait_all_results();
      case ($urandom_range(9))
        7, 8: begin
          case ($urandom_range(3))
            0:       code = 21'($urandom_range(126));
            1:       code = 21'($urandom_range(127, 21'h1FFFFF));
            default: code = 21'($urandom);
          endcase
          send_char(code, 1'($urandom));
        end
        9: begin
          if (active_slots > 0 && $urandom_range(1))
            slot = 10'($urandom_range(active_slots - 1));
          else
            slot = 10'($urandom_range(TABLE_DEPTH - 1));
          send_load(slot, $urandom_range(1) ? 11'($urandom) : 11'($urandom_range(8)),
                    pick_char(), 11'($urandom), 16'($urandom));
        end
        default: emit_text();
      endcase
    end
  endtask

  // Receiver: segments of random stall density, plus one long hold on request
  initial begin : rx_pattern
    int seg;
    int stall_pct;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        seg = $urandom_range(10, 150);
        case ($urandom_range(4))
          0, 1:    stall_pct = 0;
          2:       stall_pct = 25;
          3:       stall_pct = 50;
          default: stall_pct = 80;
        endcase
        for (int k = 0; k < seg && !hold_request; k++) begin
          out_tready <= ($urandom_range(99) >= stall_pct);
          @(posedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[trie_dfa_string_matcher_top] ERROR");
    $finish;
  end

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = OP_LOAD;
    in_tlast     = 1'b0;
    offering     = 1'b0;
    hold_request = 1'b0;
    burst_left   = 1;
    items_sent   = 0;
    active_slots = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table after reset: no transition, and rejected codes
    send_char(CH_A, 1'b0);
    send_char(21'd127, 1'b0);
    send_char(21'h1FFFFF, 1'b1);

    // small automaton: a->1, b->2 (final 32767), c->3 (final 0), NUL->2047 (sign set)
    send_load(10'd0, 11'd0, 7'h61, 11'd1, 16'hFFFF);
    send_load(10'd1, 11'd1, 7'h62, 11'd2, 16'd32767);
    send_load(10'd2, 11'd2, 7'h63, 11'd3, 16'd0);
    send_load(10'd3, 11'd3, 7'd0, 11'd2047, 16'h8000);
    send_load(10'd4, 11'd2047, 7'd126, 11'd2047, 16'hFFFF);
    // same key as slot 1, must lose to it
    send_load(10'd5, 11'd1, 7'h62, 11'd9, 16'd7);
    wait_all_results();
    set_entry_count(11'd6);

    // missing transition ends with the remembered offset, not consumed
    send_char(CH_A, 1'b0);
    send_char(CH_B, 1'b0);
    send_char(CH_X, 1'b0);
    // last of text on a taken transition, offset zero
    send_char(CH_A, 1'b0);
    send_char(CH_B, 1'b0);
    send_char(CH_C, 1'b1);
    // reject in the middle of a match
    send_char(CH_A, 1'b0);
    send_char(CH_B, 1'b0);
    send_char(21'h80, 1'b0);
    // last of text with nothing final remembered
    send_char(CH_A, 1'b1);
    // a result with the sign bit set but not all ones counts as none
    send_char(CH_A, 1'b0);
    send_char(CH_B, 1'b0);
    send_char(CH_C, 1'b0);
    send_char(21'd0, 1'b1);

    // random phases over several table sizes
    run_phase(11'd1, 1'b1, 50, -1, -1);
    run_phase(11'd12, 1'b1, 70, 20, -1);
    run_phase(11'd64, 1'b1, 90, -1, 40);
    run_phase(11'd0, 1'b1, 40, -1, -1);
    run_phase(11'd5, 1'b1, 60, -1, -1);
    run_phase(11'd40, 1'b1, 80, -1, -1);

    wait_all_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && results_due == 0)
      $display("[trie_dfa_string_matcher_top] OK");
    else
      $display("[trie_dfa_string_matcher_top] ERROR");
    $finish;
  end

endmodule
